// File: src/lrc_pkg.sv
// Package: shared types, constants and tables for the logistic residual corrector.
package lrc_pkg;
    localparam int KEY_COUNT       = 8;
    localparam int BITS_PER_SYMBOL = 8;
    localparam int BP_W  = (BITS_PER_SYMBOL > 1) ? $clog2(BITS_PER_SYMBOL) : 1;
    localparam int KI_W  = $clog2(KEY_COUNT);

    localparam logic [1:0] CFG_RATE_BASE   = 2'd0;
    localparam logic [1:0] CFG_RATE_GAIN   = 2'd1;
    localparam logic [1:0] CFG_WEIGHT_LEAK = 2'd2;
    localparam logic [1:0] CFG_ERROR_DECAY = 2'd3;

    localparam logic OP_PREDICT  = 1'b0;
    localparam logic OP_PERCEIVE = 1'b1;

    localparam int KEY_ONE = 4096;

    // datapath commands
    typedef struct packed {
        logic load_pred;
        logic load_perc;
        logic mac_step;
        logic z_step;
        logic pred_finish;
        logic beta_step;
        logic be_step;
        logic upd_step;
        logic perc_finish;
        logic [KI_W-1:0] idx;
    } lrc_cmd_t;

    function automatic logic [15:0] comp_lut(input logic [4:0] i);
        logic [15:0] v;
        case (i)
            5'd0:  v = 16'd32768; 5'd1:  v = 16'd24743; 5'd2:  v = 16'd17625;
            5'd3:  v = 16'd11955; 5'd4:  v = 16'd7812;  5'd5:  v = 16'd4971;
            5'd6:  v = 16'd3108;  5'd7:  v = 16'd1921;  5'd8:  v = 16'd1179;
            5'd9:  v = 16'd720;   5'd10: v = 16'd439;   5'd11: v = 16'd267;
            5'd12: v = 16'd162;   5'd13: v = 16'd98;    5'd14: v = 16'd60;
            5'd15: v = 16'd36;    5'd16: v = 16'd22;    5'd17: v = 16'd13;
            5'd18: v = 16'd8;     5'd19: v = 16'd5;     5'd20: v = 16'd3;
            5'd21: v = 16'd2;     5'd22: v = 16'd1;     5'd23: v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // position key for a constant bit position, Q3.12
    function automatic logic signed [15:0] pos_key(input int p);
        int t;
        if (BITS_PER_SYMBOL > 1) begin
            t = (p * 8192 + (BITS_PER_SYMBOL - 1) / 2) / (BITS_PER_SYMBOL - 1)
                - KEY_ONE;
        end else begin
            t = 0;
        end
        return 16'(t);
    endfunction
endpackage

// File: src/lrc_ctrl.sv
// Controller: sequences predict and perceive work over the shared datapath.
module lrc_ctrl import lrc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_fire,
    input  logic     s_op,
    input  logic     res_free,
    output logic     busy,
    output lrc_cmd_t cmd
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAC  = 3'd1;
    localparam logic [2:0] ST_PFIN = 3'd2;
    localparam logic [2:0] ST_BETA = 3'd3;
    localparam logic [2:0] ST_BE   = 3'd4;
    localparam logic [2:0] ST_UPD  = 3'd5;
    localparam logic [2:0] ST_UFIN = 3'd6;
    localparam logic [2:0] ST_ZST  = 3'd7;

    logic [2:0]      state_reg, state_next;
    logic [KI_W-1:0] idx_reg, idx_next;
    logic            last_idx;

    assign last_idx = (idx_reg == KI_W'(KEY_COUNT - 1));
    assign busy     = (state_reg != ST_IDLE);

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                idx_next = '0;
                if (s_fire) begin
                    if (s_op == OP_PREDICT) begin
                        cmd.load_pred = 1'b1;
                        state_next    = ST_MAC;
                    end else begin
                        cmd.load_perc = 1'b1;
                        state_next    = ST_BETA;
                    end
                end
            end
            ST_MAC: begin
                cmd.mac_step = 1'b1;
                idx_next     = idx_reg + 1'b1;
                if (last_idx) state_next = ST_ZST;
            end
            ST_ZST: begin
                cmd.z_step = 1'b1;
                state_next = ST_PFIN;
            end
            ST_PFIN: begin
                if (res_free) begin
                    cmd.pred_finish = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_BETA: begin
                cmd.beta_step = 1'b1;
                state_next    = ST_BE;
            end
            ST_BE: begin
                cmd.be_step = 1'b1;
                state_next  = ST_UPD;
            end
            ST_UPD: begin
                cmd.upd_step = 1'b1;
                idx_next     = idx_reg + 1'b1;
                if (last_idx) state_next = ST_UFIN;
            end
            ST_UFIN: begin
                cmd.perc_finish = 1'b1;
                state_next      = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end
endmodule

// File: src/lrc_datapath.sv
// Datapath: keys, weights, multipliers, logistic table and state registers.
module lrc_datapath import lrc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  lrc_cmd_t    cmd,
    input  logic [15:0] in_base_prob,
    input  logic signed [15:0] in_base_lg,
    input  logic signed [15:0] in_a_lg,
    input  logic signed [15:0] in_b_lg,
    input  logic signed [15:0] in_c_lg,
    input  logic        in_coded_bit,
    input  logic [15:0] rate_base,
    input  logic [15:0] rate_gain,
    input  logic [15:0] weight_leak,
    input  logic [15:0] error_decay,
    output logic [15:0] res_prob,
    output logic        res_fb
);
    logic signed [15:0] weights_reg [KEY_COUNT];
    logic signed [15:0] keys_reg [KEY_COUNT];
    logic [15:0]        last_prob_reg, recent_err_reg;
    logic [BP_W-1:0]    bit_pos_reg;
    logic signed [15:0] lb_reg;
    logic [15:0]        bp_reg;
    logic signed [36:0] acc_reg;
    logic signed [17:0] err_reg;
    logic [16:0]        beta_reg;
    logic signed [18:0] be_reg;
    logic signed [15:0] pos_tab [BITS_PER_SYMBOL];

    for (genvar g = 0; g < BITS_PER_SYMBOL; g++) begin : g_pos
        assign pos_tab[g] = pos_key(g);
    end

    function automatic logic signed [15:0] resid(input logic signed [15:0] x,
                                                  input logic signed [15:0] y);
        logic signed [16:0] d;
        d = 17'(x) - 17'(y);
        if (d > 17'sd4096) d = 17'sd4096;
        else if (d < -17'sd4096) d = -17'sd4096;
        return 16'(d <<< 2);
    endfunction

    // predict: dot product
    logic signed [31:0] prod_wk;
    assign prod_wk = 32'(weights_reg[cmd.idx]) * 32'(keys_reg[cmd.idx]);

    // predict: correction, then logistic
    logic signed [36:0] accr;
    logic signed [21:0] corr_w;
    logic signed [15:0] corr;
    logic signed [16:0] z, z_reg, za;
    logic [4:0]         tidx;
    logic [8:0]         frac;
    logic [15:0]        c0, c1;
    logic [25:0]        dprod;
    logic [15:0]        cval;
    logic [16:0]        p;
    logic               fb;
    logic [15:0]        bpc;

    always_comb begin
        accr   = (acc_reg + 37'sd16384) >>> 15;
        corr_w = 22'(accr);
        if (accr > 37'sd2048) corr = 16'sd2048;
        else if (accr < -37'sd2048) corr = -16'sd2048;
        else corr = 16'(corr_w);
        z = 17'(lb_reg) + 17'(corr);
    end

    always_comb begin
        za   = z_reg[16] ? -z_reg : z_reg;
        tidx = za[13:9];
        frac = za[8:0];
        c0   = comp_lut(tidx);
        c1   = comp_lut(tidx + 5'd1);
        dprod = 26'(c0 - c1) * 26'(frac);
        cval  = c0 - 16'((dprod + 26'd256) >> 9);
        if (z_reg >= 17'sd12288) p = 17'd65535;
        else if (z_reg <= -17'sd12288) p = 17'd0;
        else if (!z_reg[16]) p = (17'd65536 - 17'(cval) > 17'd65535) ? 17'd65535
                                                                  : 17'd65536 - 17'(cval);
        else p = 17'(cval);
        fb  = (p == 17'd0) || (p == 17'd65535);
        bpc = (bp_reg == 16'd0) ? 16'd1 : bp_reg;
    end

    // perceive: beta, be, weight update, recent-error update
    logic [31:0]        rg_prod;
    logic signed [35:0] be_prod;
    logic signed [31:0] leak_prod;
    logic signed [34:0] bek_prod;
    logic signed [19:0] w_new;
    logic signed [15:0] w_cl;
    logic [16:0]        aerr;
    logic [32:0]        re_sum;
    logic [17:0]        re_r;

    always_comb begin
        rg_prod   = 32'(rate_gain) * 32'(recent_err_reg);
        be_prod   = 36'(signed'({1'b0, beta_reg})) * 36'(err_reg);
        leak_prod = 32'(signed'({1'b0, weight_leak})) * 32'(weights_reg[cmd.idx]);
        bek_prod  = 35'(be_reg) * 35'(keys_reg[cmd.idx]);
        w_new = 20'((leak_prod + 32'sd32768) >>> 16) + 20'((bek_prod + 35'sd16384) >>> 15);
        if (w_new > 20'sd16384) w_cl = 16'sd16384;
        else if (w_new < -20'sd16384) w_cl = -16'sd16384;
        else w_cl = 16'(w_new);
        aerr   = err_reg[17] ? 17'(-err_reg) : 17'(err_reg);
        re_sum = 33'(error_decay) * 33'(recent_err_reg)
               + 33'(17'd65536 - 17'(error_decay)) * 33'(aerr) + 33'd32768;
        re_r   = 18'(re_sum >> 16);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KEY_COUNT; i++) begin
                weights_reg[i] <= '0;
                keys_reg[i]    <= '0;
            end
            last_prob_reg  <= 16'd32768;
            recent_err_reg <= '0;
            bit_pos_reg    <= '0;
        end else begin
            if (cmd.load_pred) begin
                keys_reg[0] <= resid(in_a_lg, in_base_lg);
                keys_reg[1] <= resid(in_b_lg, in_base_lg);
                keys_reg[2] <= resid(in_c_lg, in_base_lg);
                keys_reg[3] <= resid(in_a_lg, in_b_lg);
                keys_reg[4] <= resid(in_a_lg, in_c_lg);
                keys_reg[5] <= pos_tab[bit_pos_reg];
                keys_reg[6] <= 16'((17'(recent_err_reg) + 17'd8) >> 4);
                keys_reg[7] <= 16'(KEY_ONE);
            end
            if (cmd.pred_finish) last_prob_reg <= fb ? bpc : p[15:0];
            if (cmd.upd_step) weights_reg[cmd.idx] <= w_cl;
            if (cmd.perc_finish) begin
                recent_err_reg <= (re_r > 18'd65535) ? 16'd65535 : re_r[15:0];
                if (bit_pos_reg == BP_W'(BITS_PER_SYMBOL - 1)) bit_pos_reg <= '0;
                else bit_pos_reg <= bit_pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_pred) begin
            lb_reg  <= in_base_lg;
            bp_reg  <= in_base_prob;
            acc_reg <= '0;
        end
        if (cmd.mac_step) acc_reg <= acc_reg + 37'(prod_wk);
        if (cmd.z_step) z_reg <= z;
        if (cmd.load_perc)
            err_reg <= (in_coded_bit ? 18'sd65536 : 18'sd0) - 18'(last_prob_reg);
        if (cmd.beta_step)
            beta_reg <= 17'(rate_base) + 17'((33'(rg_prod) + 33'd32768) >> 16);
        if (cmd.be_step) be_reg <= 19'((be_prod + 36'sd32768) >>> 16);
        if (cmd.pred_finish) begin
            res_prob <= fb ? bpc : p[15:0];
            res_fb   <= fb;
        end
    end
endmodule

// File: src/logistic_residual_corrector.sv
// Top level: stream ports, configuration registers, result buffer.
//   channel | dir | handshake          | payload
//   s_      | in  | s_tvalid/s_tready  | s_tdata, s_tuser (op)
//   m_      | out | m_tvalid/m_tready  | m_tdata (prob_out), m_tuser (fell_back)
//   cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
// Predict steps: load, 8 shared multiply-accumulate steps, correction, logistic/finish.
// Perceive steps: load, rate, step size, 8 weight updates, error update.
// Synchronous active-low reset restores config registers, weights, keys and state.
// A result waits in the output register; a new predict only finishes once it is free.
module logistic_residual_corrector import lrc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // base_prob, base_lg, expert_a_lg, b, c, coded_bit, pad
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // prob_out
    output logic        m_tuser,   // fell_back
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    logic [15:0] rate_base_reg, rate_gain_reg, weight_leak_reg, error_decay_reg;
    logic        m_valid_reg;
    logic        busy, s_fire, res_free;
    lrc_cmd_t    cmd;

    assign s_tready  = !busy;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign res_free  = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_base_reg   <= 16'd328;
            rate_gain_reg   <= 16'd1311;
            weight_leak_reg <= 16'd65470;
            error_decay_reg <= 16'd65208;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_RATE_BASE:   rate_base_reg   <= cfg_data;
                    CFG_RATE_GAIN:   rate_gain_reg   <= cfg_data;
                    CFG_WEIGHT_LEAK: weight_leak_reg <= cfg_data;
                    CFG_ERROR_DECAY: error_decay_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.pred_finish) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    lrc_ctrl u_ctrl (
        .aclk, .aresetn, .s_fire, .s_op(s_tuser), .res_free, .busy, .cmd
    );

    lrc_datapath u_dp (
        .aclk, .aresetn, .cmd,
        .in_base_prob(s_tdata[15:0]),
        .in_base_lg(s_tdata[31:16]),
        .in_a_lg(s_tdata[47:32]),
        .in_b_lg(s_tdata[63:48]),
        .in_c_lg(s_tdata[79:64]),
        .in_coded_bit(s_tdata[80]),
        .rate_base(rate_base_reg), .rate_gain(rate_gain_reg),
        .weight_leak(weight_leak_reg), .error_decay(error_decay_reg),
        .res_prob(m_tdata), .res_fb(m_tuser)
    );

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");
    a_noacc: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_tready)
        else $error("input taken while busy");
    a_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pred_finish |-> res_free)
        else $error("result overwritten");
endmodule

// File: tb/logistic_residual_corrector_test.sv
// Testbench: drives predict/perceive requests and config writes, checks results against a predictor.
module logistic_residual_corrector_test;
    import lrc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        op;
        logic [15:0] bprob;
        logic [15:0] blg;
        logic [15:0] alg;
        logic [15:0] bblg;
        logic [15:0] clg;
        logic        bit_v;
        logic        chk;
        logic [15:0] exp_p;
        logic        exp_fb;
    } req_t;

    typedef struct {
        logic [15:0] p;
        logic        fb;
    } res_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [87:0] s_tdata = '0;
    logic s_tuser = 0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [15:0] m_tdata;
    logic m_tuser;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    always #6 aclk = ~aclk;

    logistic_residual_corrector uut (.*);

    // predictor state
    longint p_rb, p_rg, p_lk, p_ed;
    longint p_w[KEY_COUNT];
    longint p_k[KEY_COUNT];
    longint p_last, p_rerr, p_pos;
    res_t prob_q[$];
    int errors = 0;
    int n_pred = 0, n_perc = 0, n_fb = 0, n_got = 0;
    bit hold_rx = 0;
    int idle_cnt = 0;

    localparam longint CTAB[25] = '{32768, 24743, 17625, 11955, 7812, 4971, 3108, 1921,
        1179, 720, 439, 267, 162, 98, 60, 36, 22, 13, 8, 5, 3, 2, 1, 1, 0};

    function automatic longint rnd_shift(longint v, int sh);
        longint t;
        t = v + (longint'(1) << (sh - 1));
        return t >>> sh;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint sigm_lut(longint z);
        longint a, idx, fr, c;
        if (z >= 12288) return 65535;
        if (z <= -12288) return 0;
        a = z < 0 ? -z : z;
        idx = a >> 9;
        fr = a & 511;
        c = CTAB[idx] - rnd_shift((CTAB[idx] - CTAB[idx + 1]) * fr, 9);
        if (z >= 0) return (65536 - c > 65535) ? 65535 : 65536 - c;
        return c;
    endfunction

    task automatic predictor_reset();
        p_rb = 328; p_rg = 1311; p_lk = 65470; p_ed = 65208;
        for (int i = 0; i < KEY_COUNT; i++) begin
            p_w[i] = 0;
            p_k[i] = 0;
        end
        p_last = 32768; p_rerr = 0; p_pos = 0;
    endtask

    task automatic correct_step(input req_t r, output bit has, output res_t o);
        longint bp, lb, la, lbb, lc, acc, corr, z, p, err, aerr, beta, be, w, re;
        has = 0;
        o = '{0, 0};
        if (r.op == OP_PREDICT) begin
            bp = r.bprob; if (bp < 1) bp = 1;
            lb = $signed(r.blg); la = $signed(r.alg);
            lbb = $signed(r.bblg); lc = $signed(r.clg);
            p_k[0] = clip(la - lb, -4096, 4096) * 4;
            p_k[1] = clip(lbb - lb, -4096, 4096) * 4;
            p_k[2] = clip(lc - lb, -4096, 4096) * 4;
            p_k[3] = clip(la - lbb, -4096, 4096) * 4;
            p_k[4] = clip(la - lc, -4096, 4096) * 4;
            p_k[5] = (BITS_PER_SYMBOL > 1) ?
                (p_pos * 8192 + (BITS_PER_SYMBOL - 1) / 2) / (BITS_PER_SYMBOL - 1) - 4096 : 0;
            p_k[6] = (p_rerr + 8) >> 4;
            p_k[7] = 4096;
            acc = 0;
            for (int i = 0; i < KEY_COUNT; i++) acc += p_w[i] * p_k[i];
            corr = clip(rnd_shift(acc, 15), -2048, 2048);
            z = lb + corr;
            p = sigm_lut(z);
            o.fb = (p == 0 || p == 65535);
            if (o.fb) p = bp;
            p_last = p;
            o.p = p[15:0];
            has = 1;
        end else begin
            err = (r.bit_v ? 65536 : 0) - p_last;
            aerr = err < 0 ? -err : err;
            beta = p_rb + rnd_shift(p_rg * p_rerr, 16);
            be = rnd_shift(beta * err, 16);
            for (int i = 0; i < KEY_COUNT; i++) begin
                w = rnd_shift(p_lk * p_w[i], 16) + rnd_shift(be * p_k[i], 15);
                p_w[i] = clip(w, -16384, 16384);
            end
            re = rnd_shift(p_ed * p_rerr + (65536 - p_ed) * aerr, 16);
            p_rerr = clip(re, 0, 65535);
            p_pos = (p_pos + 1) % BITS_PER_SYMBOL;
        end
    endtask

    task automatic wait_gap();
        int n;
        n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (n > 0) begin
            s_tvalid <= 0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic send_req(input req_t r);
        bit has;
        res_t o;
        wait_gap();
        s_tvalid <= 1;
        s_tuser <= r.op;
        s_tdata <= {7'd0, r.bit_v, r.clg, r.bblg, r.alg, r.blg, r.bprob};
        do @(posedge aclk); while (!s_tready);
        correct_step(r, has, o);
        if (r.op == OP_PREDICT) n_pred++; else n_perc++;
        if (has) begin
            if (r.chk && (o.p != r.exp_p || o.fb != r.exp_fb)) begin
                $error("table row mismatch: expected %0d/%0d predicted %0d/%0d",
                       r.exp_p, r.exp_fb, o.p, o.fb);
                errors++;
            end
            prob_q.push_back(o);
        end
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] v);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_RATE_BASE:   p_rb = v;
            CFG_RATE_GAIN:   p_rg = v;
            CFG_WEIGHT_LEAK: p_lk = v;
            CFG_ERROR_DECAY: p_ed = v;
        endcase
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (prob_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [15:0] rnd_lg();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'h8000;
            2: return 16'h7FFF;
            default: return 16'($signed($urandom_range(0, 12000)) - 6000);
        endcase
    endfunction

    function automatic req_t rnd_req(input logic op);
        req_t r;
        r.op = op;
        r.bprob = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 1) * 65535)
                                              : 16'($urandom);
        r.blg = rnd_lg();
        r.alg = ($urandom_range(0, 1)) ? rnd_lg() : r.blg + 16'($urandom_range(0, 2000) - 1000);
        r.bblg = rnd_lg();
        r.clg = rnd_lg();
        r.bit_v = 1'($urandom_range(0, 1));
        r.chk = 0; r.exp_p = 0; r.exp_fb = 0;
        return r;
    endfunction

    // directed table: op, base_prob, base_lg, a, b, c, bit, check, prob, fell_back
    req_t dir_tab[] = '{
        '{OP_PREDICT, 16'd40000, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 16'd32768, 1'b0},
        '{OP_PREDICT, 16'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 1'b1, 16'd1, 1'b1},
        '{OP_PREDICT, 16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b1,
          16'hFFFF, 1'b1},
        '{OP_PREDICT, 16'd1234, 16'd12288, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 16'd1234, 1'b1},
        '{OP_PREDICT, 16'd999, 16'hD000, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 16'd999, 1'b1},
        '{OP_PERCEIVE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0, 16'd0, 1'b0},
        '{OP_PREDICT, 16'd500, 16'd1024, 16'h8000, 16'h7FFF, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{OP_PERCEIVE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0,
          16'd0, 1'b0},
        '{OP_PREDICT, 16'd7, 16'hFC00, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b1, 1'b0, 16'd0, 1'b0},
        '{OP_PERCEIVE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0, 16'd0, 1'b0},
        '{OP_PREDICT, 16'd30000, 16'd512, 16'd2000, 16'hF000, 16'd300, 1'b0, 1'b0, 16'd0, 1'b0},
        '{OP_PERCEIVE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0}
    };

    // result checker and receiver stalls
    always @(posedge aclk) begin
        res_t e;
        if (aresetn && m_tvalid && m_tready) begin
            n_got++;
            if (m_tuser) n_fb++;
            if (prob_q.size() == 0) begin
                $error("unexpected request result prob_out=%0d", m_tdata);
                errors++;
            end else begin
                e = prob_q.pop_front();
                if (m_tdata !== e.p) begin
                    $error("prob_out expected %0d actual %0d", e.p, m_tdata);
                    errors++;
                end
                if (m_tuser !== e.fb) begin
                    $error("fell_back expected %0d actual %0d", e.fb, m_tuser);
                    errors++;
                end
            end
        end
    end

    initial begin
        int n;
        wait (aresetn);
        forever begin
            m_tready <= 1;
            do @(posedge aclk); while (!(m_tvalid && m_tready) && !hold_rx);
            if (hold_rx) begin
                m_tready <= 0;
                repeat (300) @(posedge aclk);
                hold_rx = 0;
            end else begin
                n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
                if (n > 0) begin
                    m_tready <= 0;
                    repeat (n) @(posedge aclk);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !aresetn || hold_rx)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > 5000) begin
            $display("FAIL logistic_residual_corrector");
            $finish;
        end
    end

    initial begin
        logic [15:0] cfgs[5][4];
        predictor_reset();
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        foreach (dir_tab[i]) send_req(dir_tab[i]);
        drain();
        cfgs[0] = '{16'd328, 16'd1311, 16'd65470, 16'd65208};
        cfgs[1] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        cfgs[2] = '{16'd0, 16'd0, 16'd0, 16'd0};
        cfgs[3] = '{16'd4000, 16'd20000, 16'd60000, 16'd50000};
        cfgs[4] = '{16'd328, 16'd1311, 16'd65470, 16'd65208};
        for (int ph = 0; ph < 5; ph++) begin
            cfg_write(CFG_RATE_BASE, cfgs[ph][0]);
            cfg_write(CFG_RATE_GAIN, cfgs[ph][1]);
            cfg_write(CFG_WEIGHT_LEAK, cfgs[ph][2]);
            cfg_write(CFG_ERROR_DECAY, cfgs[ph][3]);
            cfg_valid <= 0;
            if (ph == 1) hold_rx = 1;
            for (int i = 0; i < 125; i++) begin
                // mostly a predict followed by its perceive, some noise
                if ($urandom_range(0, 4) != 0) begin
                    send_req(rnd_req(OP_PREDICT));
                    send_req(rnd_req(OP_PERCEIVE));
                end else begin
                    send_req(rnd_req(logic'($urandom_range(0, 1))));
                    send_req(rnd_req(logic'($urandom_range(0, 1))));
                end
            end
            drain();
        end
        $display("covered %0d predicts, %0d perceives, %0d results (%0d fallbacks)",
                 n_pred, n_perc, n_got, n_fb);
        $display("five register settings including all-zero and all-ones, one long stall");
        if (errors == 0 && prob_q.size() == 0) begin
            $display("PASS logistic_residual_corrector");
        end else begin
            $display("FAIL logistic_residual_corrector");
        end
        $finish;
    end
endmodule
